>>> rtl/bilinear_texture_sampler_unit_macros.svh
// Assertion macros used by the top level of the bilinear texture sampler RTL.
`ifndef BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define BTSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define BTSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/btsu_pkg.sv
// Types, constants and helper functions of the bilinear texture sampler.
`default_nettype none

package btsu_pkg;

    // Store geometry.
    localparam int MAX_DIM     = 64;
    localparam int MIP_LEVELS  = 7;
    localparam int WEIGHT_BITS = 8;

    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int SIZE_W      = DIM_W + 1;
    localparam int LEVEL_WORDS = MAX_DIM * MAX_DIM;
    localparam int STORE_WORDS = MIP_LEVELS * LEVEL_WORDS;
    localparam int ADDR_W      = $clog2(STORE_WORDS);

    // Field widths of the channels and the configuration port.
    localparam int LEVEL_W    = 3;
    localparam int TEX_XY_W   = 6;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int TEXEL_W    = CH_W * NUM_CH;
    localparam int COORD_W    = 17;
    localparam int COORD_FRAC = 16;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;

    // Coordinate arithmetic.
    localparam int PROD_W = COORD_W + SIZE_W;
    localparam int Q_W    = COORD_FRAC + SIZE_W;
    localparam logic [COORD_W-1:0] COORD_ONE  = COORD_W'(2 ** COORD_FRAC);
    localparam logic [PROD_W-1:0]  COORD_HALF = PROD_W'(2 ** (COORD_FRAC - 1));

    // Blend arithmetic.
    localparam int WT_W  = WEIGHT_BITS + 1;
    localparam int TOP_W = CH_W + WEIGHT_BITS + 1;
    localparam int ACC_W = TOP_W + WEIGHT_BITS + 1;
    localparam logic [WT_W-1:0]  WT_ONE    = WT_W'(2 ** WEIGHT_BITS);
    localparam logic [ACC_W-1:0] ACC_ROUND = ACC_W'(2 ** (2 * WEIGHT_BITS - 1));

    // Four neighbours: (x0,y0), (x1,y0), (x0,y1), (x1,y1).
    localparam int NBR = 4;

    // Operation codes.
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = CFG_IDX_W'(1);

    typedef struct packed {
        logic                func;
        logic [LEVEL_W-1:0]  level;
        logic [TEX_XY_W-1:0] tex_x;
        logic [TEX_XY_W-1:0] tex_y;
        logic [CH_W-1:0]     texel_r;
        logic [CH_W-1:0]     texel_g;
        logic [CH_W-1:0]     texel_b;
        logic [CH_W-1:0]     texel_a;
        logic [COORD_W-1:0]  coord_u;
        logic [COORD_W-1:0]  coord_v;
    } t_req_item;

    typedef struct packed {
        logic valid;
        logic sample;
    } t_a_status;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [TEXEL_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic [NBR-1:0][ADDR_W-1:0] addr;
        logic [WEIGHT_BITS-1:0]     s;
        logic [WEIGHT_BITS-1:0]     t;
    } t_rd_req;

    typedef struct packed {
        logic b_valid;
        logic c_load;
        logic d_load;
    } t_pipe_ctl;

    typedef struct packed {
        logic c_valid;
        logic d_valid;
    } t_blend_stat;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_rgba;

    // Size of one mip level: the base size shifted down, never below one texel.
    function automatic logic [SIZE_W-1:0] level_size(input logic [SIZE_W-1:0] base,
                                                     input logic [LEVEL_W-1:0] lvl);
        logic [SIZE_W-1:0] sz;
        sz = base >> lvl;
        if (sz == '0) begin
            sz = SIZE_W'(1);
        end
        return sz;
    endfunction

    // Linear store address of a texel.
    function automatic logic [ADDR_W-1:0] texel_addr(input logic [LEVEL_W-1:0] lvl,
                                                     input logic [DIM_W-1:0]   x,
                                                     input logic [DIM_W-1:0]   y);
        return ADDR_W'(lvl) * ADDR_W'(LEVEL_WORDS) + ADDR_W'(y) * ADDR_W'(MAX_DIM)
               + ADDR_W'(x);
    endfunction

endpackage

`default_nettype wire

>>> rtl/btsu_if.sv
// Request and result channel interfaces of the bilinear texture sampler.
`default_nettype none

interface btsu_req_if import btsu_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                func;
    logic [LEVEL_W-1:0]  level;
    logic [TEX_XY_W-1:0] tex_x;
    logic [TEX_XY_W-1:0] tex_y;
    logic [CH_W-1:0]     texel_r;
    logic [CH_W-1:0]     texel_g;
    logic [CH_W-1:0]     texel_b;
    logic [CH_W-1:0]     texel_a;
    logic [COORD_W-1:0]  coord_u;
    logic [COORD_W-1:0]  coord_v;

    modport source (
        output valid, func, level, tex_x, tex_y,
        output texel_r, texel_g, texel_b, texel_a, coord_u, coord_v,
        input  ready
    );
    modport sink (
        input  valid, func, level, tex_x, tex_y,
        input  texel_r, texel_g, texel_b, texel_a, coord_u, coord_v,
        output ready
    );
endinterface

interface btsu_rsp_if import btsu_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] out_r;
    logic [CH_W-1:0] out_g;
    logic [CH_W-1:0] out_b;
    logic [CH_W-1:0] out_a;

    modport source (output valid, out_r, out_g, out_b, out_a, input ready);
    modport sink (input valid, out_r, out_g, out_b, out_a, output ready);
endinterface

`default_nettype wire

>>> rtl/btsu_ram.sv
// One copy of the texel store: one write port, one registered read port.
`default_nettype none

module btsu_ram import btsu_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [ADDR_W-1:0]  i_waddr,
    input  wire logic [TEXEL_W-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [ADDR_W-1:0]  i_raddr,
    output logic      [TEXEL_W-1:0] o_rdata
);

    logic [TEXEL_W-1:0] mem [STORE_WORDS];
    logic [TEXEL_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data register holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/btsu_coord.sv
// Coordinate stage: level sizes, texel positions, weights and store addresses.
`default_nettype none

module btsu_coord import btsu_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic              i_accept,
    input  wire t_req_item         i_item,
    input  wire logic [SIZE_W-1:0] i_base_w,
    input  wire logic [SIZE_W-1:0] i_base_h,
    output t_a_status              o_stat,
    output t_mem_wr                o_wr,
    output t_rd_req                o_rd
);

    logic [LEVEL_W-1:0]  lvl_sat;
    logic                lvl_ok;
    logic [SIZE_W-1:0]   size_w;
    logic [SIZE_W-1:0]   size_h;
    logic [COORD_W-1:0]  u_sat;
    logic [COORD_W-1:0]  v_sat;
    logic [PROD_W-1:0]   qx_full;
    logic [PROD_W-1:0]   qy_full;

    logic                r_valid;
    logic                r_sample;
    logic                r_wr_ok;
    logic [LEVEL_W-1:0]  r_lvl;
    logic [TEX_XY_W-1:0] r_x;
    logic [TEX_XY_W-1:0] r_y;
    logic [TEXEL_W-1:0]  r_wdata;
    logic [Q_W-1:0]      r_qx;
    logic [Q_W-1:0]      r_qy;
    logic [SIZE_W-1:0]   r_w;
    logic [SIZE_W-1:0]   r_h;

    logic [SIZE_W-1:0]   qxi;
    logic [SIZE_W-1:0]   qyi;
    logic [SIZE_W-1:0]   x0;
    logic [SIZE_W-1:0]   x1;
    logic [SIZE_W-1:0]   y0;
    logic [SIZE_W-1:0]   y1;

    // Level saturation, level sizes and the scaled coordinates offset by half a texel.
    always_comb begin
        lvl_ok  = 32'(i_item.level) < 32'(MIP_LEVELS);
        lvl_sat = lvl_ok ? i_item.level : LEVEL_W'(MIP_LEVELS - 1);
        size_w  = level_size(i_base_w, lvl_sat);
        size_h  = level_size(i_base_h, lvl_sat);
        u_sat   = (i_item.coord_u > COORD_ONE) ? COORD_ONE : i_item.coord_u;
        v_sat   = (i_item.coord_v > COORD_ONE) ? COORD_ONE : i_item.coord_v;
        qx_full = PROD_W'(u_sat) * PROD_W'(size_w) + COORD_HALF;
        qy_full = PROD_W'(v_sat) * PROD_W'(size_h) + COORD_HALF;
    end

    // Stage valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_accept;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_sample <= (i_item.func == FUNC_SAMPLE);
            r_wr_ok  <= lvl_ok;
            r_lvl    <= lvl_sat;
            r_x      <= i_item.tex_x;
            r_y      <= i_item.tex_y;
            r_wdata  <= {i_item.texel_a, i_item.texel_b, i_item.texel_g, i_item.texel_r};
            r_qx     <= qx_full[Q_W-1:0];
            r_qy     <= qy_full[Q_W-1:0];
            r_w      <= size_w;
            r_h      <= size_h;
        end
    end

    // Neighbour positions clamped to the level's edges. The integer part of the
    // offset coordinate is one above the lower neighbour.
    always_comb begin
        qxi = r_qx[COORD_FRAC +: SIZE_W];
        qyi = r_qy[COORD_FRAC +: SIZE_W];

        if (qxi == '0) begin
            x0 = '0;
        end else if (qxi > r_w) begin
            x0 = r_w - SIZE_W'(1);
        end else begin
            x0 = qxi - SIZE_W'(1);
        end
        x1 = (qxi >= r_w) ? r_w - SIZE_W'(1) : qxi;

        if (qyi == '0) begin
            y0 = '0;
        end else if (qyi > r_h) begin
            y0 = r_h - SIZE_W'(1);
        end else begin
            y0 = qyi - SIZE_W'(1);
        end
        y1 = (qyi >= r_h) ? r_h - SIZE_W'(1) : qyi;
    end

    // Read addresses and weights of a sample.
    always_comb begin
        o_rd.addr[0] = texel_addr(r_lvl, x0[DIM_W-1:0], y0[DIM_W-1:0]);
        o_rd.addr[1] = texel_addr(r_lvl, x1[DIM_W-1:0], y0[DIM_W-1:0]);
        o_rd.addr[2] = texel_addr(r_lvl, x0[DIM_W-1:0], y1[DIM_W-1:0]);
        o_rd.addr[3] = texel_addr(r_lvl, x1[DIM_W-1:0], y1[DIM_W-1:0]);
        o_rd.s       = r_qx[COORD_FRAC-1 -: WEIGHT_BITS];
        o_rd.t       = r_qy[COORD_FRAC-1 -: WEIGHT_BITS];
    end

    // Write command of a texel write; a write to a level beyond the store is dropped.
    always_comb begin
        o_wr.en   = r_valid && !r_sample && r_wr_ok;
        o_wr.addr = texel_addr(r_lvl, DIM_W'(r_x), DIM_W'(r_y));
        o_wr.data = r_wdata;
    end

    assign o_stat.valid  = r_valid;
    assign o_stat.sample = r_sample;

endmodule

`default_nettype wire

>>> rtl/btsu_blend.sv
// Blend stages: horizontal lerp of both rows, then vertical lerp with rounding.
`default_nettype none

module btsu_blend import btsu_pkg::*; (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire t_pipe_ctl                      i_ctl,
    input  wire logic [WEIGHT_BITS-1:0]         i_s,
    input  wire logic [WEIGHT_BITS-1:0]         i_t,
    input  wire logic [NBR-1:0][TEXEL_W-1:0]    i_texel,
    output t_blend_stat                         o_stat,
    output t_rgba                               o_rgba
);

    logic [WT_W-1:0]                  s_inv;
    logic [WT_W-1:0]                  t_inv;
    logic [NUM_CH-1:0][TOP_W-1:0]     n_top;
    logic [NUM_CH-1:0][TOP_W-1:0]     n_bot;
    logic [NUM_CH-1:0][ACC_W-1:0]     acc;
    t_rgba                            n_out;

    logic                             r_c_valid;
    logic [NUM_CH-1:0][TOP_W-1:0]     r_top;
    logic [NUM_CH-1:0][TOP_W-1:0]     r_bot;
    logic [WEIGHT_BITS-1:0]           r_t;
    logic                             r_d_valid;
    t_rgba                            r_out;

    // Horizontal blend of the upper and the lower row, per channel.
    always_comb begin
        s_inv = WT_ONE - WT_W'(i_s);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_top[ch] = TOP_W'(i_texel[0][ch*CH_W +: CH_W]) * TOP_W'(s_inv)
                      + TOP_W'(i_texel[1][ch*CH_W +: CH_W]) * TOP_W'(i_s);
            n_bot[ch] = TOP_W'(i_texel[2][ch*CH_W +: CH_W]) * TOP_W'(s_inv)
                      + TOP_W'(i_texel[3][ch*CH_W +: CH_W]) * TOP_W'(i_s);
        end
    end

    // Vertical blend and round half up; the result never exceeds the channel range.
    always_comb begin
        t_inv = WT_ONE - WT_W'(r_t);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            acc[ch]   = ACC_W'(r_top[ch]) * ACC_W'(t_inv) + ACC_W'(r_bot[ch]) * ACC_W'(r_t)
                      + ACC_ROUND;
            n_out[ch] = acc[ch][2*WEIGHT_BITS +: CH_W];
        end
    end

    // Valid bits of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (i_ctl.c_load) begin
                r_c_valid <= i_ctl.b_valid;
            end
            if (i_ctl.d_load) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_ctl.c_load) begin
            r_top <= n_top;
            r_bot <= n_bot;
            r_t   <= i_t;
        end
        if (i_ctl.d_load) begin
            r_out <= n_out;
        end
    end

    assign o_stat.c_valid = r_c_valid;
    assign o_stat.d_valid = r_d_valid;
    assign o_rgba         = r_out;

endmodule

`default_nettype wire

>>> rtl/bilinear_texture_sampler_unit.sv
// Top level of the bilinear RGBA8 texture sampler.
`default_nettype none
`include "bilinear_texture_sampler_unit_macros.svh"

// The sampler takes one item per clock cycle, writes and samples alike, when
// the result side keeps up. The four neighbours of a sample are read in the
// same cycle from four copies of the texel store, one read port each; every
// texel write goes to all four copies. The pipeline has four stages
// (coordinates, store read, row blend, column blend), the last of which drives
// the result channel, and each stage moves on when the one after it is empty
// or moving, so empty stages are filled while a result waits. Writes reach the
// store in item order with the reads, so a sample sees every write accepted
// before it. The store has no reset and needs no clearing pass: a texel must
// be written before it is sampled. The level sizes are to be written through
// the configuration port only while no item is in flight, a rule the block
// leaves to the user; values out of range are clamped to 1 to 64.
module bilinear_texture_sampler_unit import btsu_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    btsu_req_if.sink                  i_req,
    btsu_rsp_if.source                o_rsp
);

    logic [SIZE_W-1:0]            r_base_w;
    logic [SIZE_W-1:0]            r_base_h;
    logic [SIZE_W-1:0]            n_base;

    t_req_item                    req_item;
    logic                         accept;
    logic                         a_load;
    logic                         b_load;
    logic                         c_load;
    logic                         d_load;
    t_a_status                    a_stat;
    t_mem_wr                      mem_wr;
    t_rd_req                      rd_req;
    logic [NBR-1:0][TEXEL_W-1:0]  rd_texel;

    logic                         r_b_valid;
    logic [WEIGHT_BITS-1:0]       r_b_s;
    logic [WEIGHT_BITS-1:0]       r_b_t;

    t_pipe_ctl                    pipe_ctl;
    t_blend_stat                  blend_stat;
    t_rgba                        rgba;

    // Configuration value clamped to the legal size range.
    always_comb begin
        if (i_cfg_data == '0) begin
            n_base = SIZE_W'(1);
        end else if (i_cfg_data > CFG_W'(MAX_DIM)) begin
            n_base = SIZE_W'(MAX_DIM);
        end else begin
            n_base = SIZE_W'(i_cfg_data);
        end
    end

    // Level-zero size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_w <= SIZE_W'(MAX_DIM);
            r_base_h <= SIZE_W'(MAX_DIM);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE_WIDTH:  r_base_w <= n_base;
                REG_BASE_HEIGHT: r_base_h <= n_base;
                default: ;
            endcase
        end
    end

    // Stage advance: a stage loads when it is empty or the stage after it loads.
    always_comb begin
        d_load = !blend_stat.d_valid || o_rsp.ready;
        c_load = !blend_stat.c_valid || d_load;
        b_load = !r_b_valid || c_load;
        a_load = !a_stat.valid || b_load;
    end

    assign i_req.ready = a_load;
    assign accept      = i_req.valid && a_load;

    // Request payload gathered into one item.
    always_comb begin
        req_item.func    = i_req.func;
        req_item.level   = i_req.level;
        req_item.tex_x   = i_req.tex_x;
        req_item.tex_y   = i_req.tex_y;
        req_item.texel_r = i_req.texel_r;
        req_item.texel_g = i_req.texel_g;
        req_item.texel_b = i_req.texel_b;
        req_item.texel_a = i_req.texel_a;
        req_item.coord_u = i_req.coord_u;
        req_item.coord_v = i_req.coord_v;
    end

    btsu_coord u_coord (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (a_load),
        .i_accept (accept),
        .i_item   (req_item),
        .i_base_w (r_base_w),
        .i_base_h (r_base_h),
        .o_stat   (a_stat),
        .o_wr     (mem_wr),
        .o_rd     (rd_req)
    );

    // Four copies of the texel store, one per neighbour.
    for (genvar k = 0; k < NBR; k++) begin : g_bank
        btsu_ram u_ram (
            .i_clk   (i_clk),
            .i_we    (mem_wr.en && b_load),
            .i_waddr (mem_wr.addr),
            .i_wdata (mem_wr.data),
            .i_re    (b_load),
            .i_raddr (rd_req.addr[k]),
            .o_rdata (rd_texel[k])
        );
    end

    // Store read stage: only samples travel on; the texel data sits in the banks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_load) begin
            r_b_valid <= a_stat.valid && a_stat.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_load) begin
            r_b_s <= rd_req.s;
            r_b_t <= rd_req.t;
        end
    end

    assign pipe_ctl.b_valid = r_b_valid;
    assign pipe_ctl.c_load  = c_load;
    assign pipe_ctl.d_load  = d_load;

    btsu_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pipe_ctl),
        .i_s     (r_b_s),
        .i_t     (r_b_t),
        .i_texel (rd_texel),
        .o_stat  (blend_stat),
        .o_rgba  (rgba)
    );

    // Result channel.
    assign o_rsp.valid = blend_stat.d_valid;
    assign o_rsp.out_r = rgba[0];
    assign o_rsp.out_g = rgba[1];
    assign o_rsp.out_b = rgba[2];
    assign o_rsp.out_a = rgba[3];

    // An empty coordinate stage always takes a new transfer.
    `BTSU_ASSERT_NOW(a_empty_takes_item, i_clk, i_rst_n, !a_stat.valid, i_req.ready, "coordinate stage empty but request not ready")

    // A stalled read stage keeps its texel data in the first and last banks.
    `BTSU_ASSERT_NEXT(b_stall_holds_data, i_clk, i_rst_n, r_b_valid && !c_load, $stable(rd_texel[0]) && $stable(rd_texel[3]), "texel data lost during stall")

    // The level sizes stay within the legal range.
    `BTSU_ASSERT_NOW(base_size_legal, i_clk, i_rst_n, 1'b1, (r_base_w != '0) && (r_base_w <= SIZE_W'(MAX_DIM)) && (r_base_h != '0) && (r_base_h <= SIZE_W'(MAX_DIM)), "level-zero size out of range")

endmodule

`default_nettype wire

>>> sim/bilinear_texture_sampler_unit_tb.sv
// Self-checking testbench of the bilinear texture sampler: texel writes, samples and size settings.
`default_nettype none

module bilinear_texture_sampler_unit_tb;
    import btsu_pkg::*;

    localparam int W_ONE          = 1 << WEIGHT_BITS;
    localparam int BLEND_ROUND    = 1 << (2 * WEIGHT_BITS - 1);
    localparam int NUM_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 88;
    localparam int QUIET_PHASE    = 2;
    localparam int PAUSE_PHASE    = 3;
    localparam int SETTLE_CYCLES  = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    btsu_req_if req_ch ();
    btsu_rsp_if rsp_ch ();

    bilinear_texture_sampler_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // Local copy of the texel store and of the level-zero size.
    logic [TEXEL_W-1:0] texels        [STORE_WORDS];
    bit                 texel_written [STORE_WORDS];
    int                 base_w = MAX_DIM;
    int                 base_h = MAX_DIM;

    t_req_item pending_reqs [$];
    t_rgba     expected_rgba [$];
    int        queued_items;
    int        mismatch_count;
    int        results_seen;
    int        gap_pct;
    int        stall_pct;
    int        gap_left;
    int        stall_left;
    string     ch_names [NUM_CH] = '{"red", "green", "blue", "alpha"};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int store_index(input int lvl, input int x, input int y);
        return lvl * LEVEL_WORDS + y * MAX_DIM + x;
    endfunction

    function automatic int clamp_dim(input int v);
        return (v < 1) ? 1 : ((v > MAX_DIM) ? MAX_DIM : v);
    endfunction

    function automatic int level_dim(input int base, input int lvl);
        int d;
        d = base >> lvl;
        return (d < 1) ? 1 : d;
    endfunction

    function automatic int clamp_edge(input int k, input int size);
        if (k < 0) return 0;
        if (k > size - 1) return size - 1;
        return k;
    endfunction

    // Splits coord * size - 0.5 into two clamped neighbour indices and a weight.
    function automatic void split_axis(input logic [COORD_W-1:0] coord, input int size,
                                       output int lo, output int hi, output int frac);
        int c;
        int q;
        c = (coord > COORD_ONE) ? int'(COORD_ONE) : int'(coord);
        // Adding the half rather than taking it off keeps q positive; the floor is one lower.
        q = c * size + (1 << (COORD_FRAC - 1));
        lo = clamp_edge((q >> COORD_FRAC) - 1, size);
        hi = clamp_edge(q >> COORD_FRAC, size);
        frac = (q & ((1 << COORD_FRAC) - 1)) >> (COORD_FRAC - WEIGHT_BITS);
    endfunction

    // Level, neighbour positions and weights of one sample under the current sizes.
    function automatic void sample_taps(input t_req_item it, output int lvl,
                                        output int x0, output int x1,
                                        output int y0, output int y1,
                                        output int s, output int tw);
        lvl = (it.level >= MIP_LEVELS) ? MIP_LEVELS - 1 : int'(it.level);
        split_axis(it.coord_u, level_dim(base_w, lvl), x0, x1, s);
        split_axis(it.coord_v, level_dim(base_h, lvl), y0, y1, tw);
    endfunction

    function automatic t_rgba bilinear_filter(input t_req_item it);
        int lvl, x0, x1, y0, y1, s, tw;
        int top, bot, acc;
        logic [TEXEL_W-1:0] c00, c10, c01, c11;
        t_rgba px;
        sample_taps(it, lvl, x0, x1, y0, y1, s, tw);
        c00 = texels[store_index(lvl, x0, y0)];
        c10 = texels[store_index(lvl, x1, y0)];
        c01 = texels[store_index(lvl, x0, y1)];
        c11 = texels[store_index(lvl, x1, y1)];
        for (int ch = 0; ch < NUM_CH; ch++) begin
            top = int'(c00[ch*CH_W +: CH_W]) * (W_ONE - s) + int'(c10[ch*CH_W +: CH_W]) * s;
            bot = int'(c01[ch*CH_W +: CH_W]) * (W_ONE - s) + int'(c11[ch*CH_W +: CH_W]) * s;
            acc = top * (W_ONE - tw) + bot * tw;
            px[ch] = CH_W'((acc + BLEND_ROUND) >> (2 * WEIGHT_BITS));
        end
        return px;
    endfunction

    function automatic t_req_item random_item();
        t_req_item it;
        it.func    = 1'($urandom);
        it.level   = LEVEL_W'($urandom);
        it.tex_x   = TEX_XY_W'($urandom);
        it.tex_y   = TEX_XY_W'($urandom);
        it.texel_r = CH_W'($urandom);
        it.texel_g = CH_W'($urandom);
        it.texel_b = CH_W'($urandom);
        it.texel_a = CH_W'($urandom);
        it.coord_u = COORD_W'($urandom);
        it.coord_v = COORD_W'($urandom);
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic queue_write(input int lvl, input int x, input int y,
                               input logic [TEXEL_W-1:0] rgba);
        t_req_item it;
        it = random_item();
        it.func  = FUNC_WRITE;
        it.level = LEVEL_W'(lvl);
        it.tex_x = TEX_XY_W'(x);
        it.tex_y = TEX_XY_W'(y);
        {it.texel_a, it.texel_b, it.texel_g, it.texel_r} = rgba;
        if (lvl < MIP_LEVELS) begin
            texel_written[store_index(lvl, x, y)] = 1'b1;
        end
        pending_reqs.push_back(it);
        queued_items++;
    endtask

    // A sample is preceded by writes of any neighbour not yet written, and now
    // and then by a rewrite of one that was, to catch a stale store read.
    task automatic queue_sample(input int level, input int u, input int v);
        t_req_item it;
        int lvl, x0, x1, y0, y1, s, tw;
        int xs [4];
        int ys [4];
        it = random_item();
        it.func    = FUNC_SAMPLE;
        it.level   = LEVEL_W'(level);
        it.coord_u = COORD_W'(u);
        it.coord_v = COORD_W'(v);
        sample_taps(it, lvl, x0, x1, y0, y1, s, tw);
        xs = '{x0, x1, x0, x1};
        ys = '{y0, y0, y1, y1};
        for (int k = 0; k < 4; k++) begin
            if (!texel_written[store_index(lvl, xs[k], ys[k])] || $urandom_range(11) == 0) begin
                queue_write(lvl, xs[k], ys[k], $urandom);
            end
        end
        pending_reqs.push_back(it);
        queued_items++;
    endtask

    function automatic int pick_coord();
        case ($urandom_range(7))
            0: return 0;
            1: return int'(COORD_ONE);
            2: return $urandom_range(int'(COORD_ONE) + 1, (1 << COORD_W) - 1);
            default: return $urandom_range(0, int'(COORD_ONE));
        endcase
    endfunction

    task automatic add_random_items(input int count);
        int stop_at;
        stop_at = queued_items + count;
        while (queued_items < stop_at) begin
            if ($urandom_range(9) < 3) begin
                queue_write($urandom_range(7), $urandom_range(MAX_DIM - 1),
                            $urandom_range(MAX_DIM - 1), $urandom);
            end else begin
                queue_sample($urandom_range(7), pick_coord(), pick_coord());
            end
        end
    endtask

    // Both size registers are written back to back, only while nothing is in flight.
    task automatic set_base_dims(input int w, input int h);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_BASE_WIDTH;
        i_cfg_data <= CFG_W'(w);
        @(posedge i_clk);
        i_cfg_idx  <= REG_BASE_HEIGHT;
        i_cfg_data <= CFG_W'(h);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        base_w = clamp_dim(w & 'h7F);
        base_h = clamp_dim(h & 'h7F);
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_ch.valid || expected_rgba.size() != 0);
        // Writes leave no result behind, so give the pipeline time to empty.
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_request(input t_req_item it);
        if (it.func == FUNC_WRITE) begin
            if (it.level < MIP_LEVELS) begin
                texels[store_index(it.level, it.tex_x, it.tex_y)] =
                    {it.texel_a, it.texel_b, it.texel_g, it.texel_r};
            end
        end else begin
            expected_rgba.push_back(bilinear_filter(it));
        end
    endtask

    task automatic check_result();
        t_rgba got;
        t_rgba want;
        got = {rsp_ch.out_a, rsp_ch.out_b, rsp_ch.out_g, rsp_ch.out_r};
        results_seen++;
        if (expected_rgba.size() == 0) begin
            report_mismatch($sformatf("result %0d (%h) arrived with no sample waiting",
                                      results_seen, got));
            return;
        end
        want = expected_rgba.pop_front();
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (got[ch] !== want[ch]) begin
                report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                          results_seen, ch_names[ch], got[ch], want[ch]));
            end
        end
    endtask

    // Request driver: a transfer retires the head of the queue; valid stays up
    // until its transfer, and idle bursts are only started between items.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (req_ch.valid && !req_ch.ready) begin
            // Hold the current item.
        end else begin
            if (req_ch.valid) begin
                apply_request(pending_reqs.pop_front());
            end
            if (gap_left > 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() != 0 && $urandom_range(99) < gap_pct) begin
                gap_left = $urandom_range(1, 8) - 1;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                req_ch.valid   <= 1'b1;
                req_ch.func    <= pending_reqs[0].func;
                req_ch.level   <= pending_reqs[0].level;
                req_ch.tex_x   <= pending_reqs[0].tex_x;
                req_ch.tex_y   <= pending_reqs[0].tex_y;
                req_ch.texel_r <= pending_reqs[0].texel_r;
                req_ch.texel_g <= pending_reqs[0].texel_g;
                req_ch.texel_b <= pending_reqs[0].texel_b;
                req_ch.texel_a <= pending_reqs[0].texel_a;
                req_ch.coord_u <= pending_reqs[0].coord_u;
                req_ch.coord_v <= pending_reqs[0].coord_v;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                check_result();
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if ($urandom_range(99) < stall_pct) begin
                stall_left = $urandom_range(1, 8) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus: directed items at the reset sizes, then random phases, each at its own sizes.
    initial begin
        int phase_w [NUM_PHASES];
        int phase_h [NUM_PHASES];
        phase_w = '{0, 64, 37, 1, -1, 64};
        phase_h = '{127, 1, 5, 1, -1, 64};
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = REG_BASE_WIDTH;
        i_cfg_data     = '0;
        req_ch.valid   = 1'b0;
        req_ch.func    = FUNC_WRITE;
        req_ch.level   = '0;
        req_ch.tex_x   = '0;
        req_ch.tex_y   = '0;
        req_ch.texel_r = '0;
        req_ch.texel_g = '0;
        req_ch.texel_b = '0;
        req_ch.texel_a = '0;
        req_ch.coord_u = '0;
        req_ch.coord_v = '0;
        rsp_ch.ready   = 1'b0;
        gap_pct        = 15;
        stall_pct      = 15;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Channel extremes at the corners, an ignored level and a write beyond the level size.
        queue_write(0, 0, 0, 32'h0000_0000);
        queue_write(0, MAX_DIM - 1, MAX_DIM - 1, 32'hFFFF_FFFF);
        queue_write(0, MAX_DIM - 1, 0, 32'hFF00_FF00);
        queue_write(0, 0, MAX_DIM - 1, 32'h00FF_00FF);
        queue_write(MIP_LEVELS, 5, 5, 32'h1234_5678);
        queue_write(5, MAX_DIM - 1, MAX_DIM - 1, 32'hA5A5_A5A5);
        // Edge clamping low and high, coordinates above one, the smallest
        // level, a level beyond the last and a half-way blend.
        queue_sample(0, 0, 0);
        queue_sample(0, int'(COORD_ONE), int'(COORD_ONE));
        queue_sample(0, (1 << COORD_W) - 1, (1 << COORD_W) - 1);
        queue_sample(0, 0, int'(COORD_ONE));
        queue_sample(MIP_LEVELS - 1, 40000, 20000);
        queue_sample(7, int'(COORD_ONE), (1 << COORD_W) - 1);
        queue_sample(0, 32768, 32768);
        queue_sample(3, 12345, 54321);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_for_drain();
            set_base_dims((phase_w[ph] < 0) ? $urandom_range(127) : phase_w[ph],
                          (phase_h[ph] < 0) ? $urandom_range(127) : phase_h[ph]);
            if (ph == QUIET_PHASE || ph == NUM_PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = 20;
                stall_pct = 20;
            end
            add_random_items(ITEMS_PER_PHASE / 2);
            // The sender holds off here until every outstanding sample has returned.
            if (ph == PAUSE_PHASE) begin
                wait_for_drain();
            end
            add_random_items(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
        end

        wait_for_drain();
        if (mismatch_count == 0) begin
            $display("bilinear_texture_sampler_unit verification clean");
        end else begin
            $display("bilinear_texture_sampler_unit verification failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2000000;
        $display("bilinear_texture_sampler_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/btsu_pkg.sv
rtl/btsu_if.sv
rtl/btsu_ram.sv
rtl/btsu_coord.sv
rtl/btsu_blend.sv
rtl/bilinear_texture_sampler_unit.sv
sim/bilinear_texture_sampler_unit_tb.sv
